// ===== hdl/csgc_pkg.sv =====
// shared types, codes and constants of the color sensor gain calibration unit
`default_nettype none

package csgc_pkg;

    localparam int READING_W         = 16;
    localparam int INTEG_W           = 12;
    localparam int CAP_W             = 4;
    localparam int PHASE_W           = 3;
    localparam int APB_DATA_W        = 32;
    localparam int APB_ADDR_W        = 2;

    localparam int SEARCH_RANGE_DEF  = 4096;

    // samples averaged per capacitor step, a power of two
    localparam int AVG_SAMPLES       = 4;
    localparam int AVG_SHIFT         = $clog2(AVG_SAMPLES);
    localparam int SUM_W             = READING_W + AVG_SHIFT;
    localparam int CNT_W             = (AVG_SHIFT > 0) ? AVG_SHIFT : 1;

    localparam logic [READING_W-1:0] TARGET_RESET = 16'd1000;
    localparam logic [READING_W-1:0] SPREAD_INIT  = 16'd5000;
    localparam logic [CAP_W-1:0]     CAP_MAX      = 4'd15;

    // register byte addresses
    localparam logic [APB_ADDR_W-1:0] REG_ADDR_TARGET = 2'd0;

    // request command codes
    localparam logic CMD_START   = 1'b0;
    localparam logic CMD_MEASURE = 1'b1;

    typedef enum logic [PHASE_W-1:0] {
        PH_IDLE  = 3'd0,
        PH_COLOR = 3'd1,
        PH_CLEAR = 3'd2,
        PH_CAPS  = 3'd3,
        PH_DONE  = 3'd4
    } phase_t;

    typedef struct packed {
        logic                 cmd;
        logic [READING_W-1:0] red_reading;
        logic [READING_W-1:0] green_reading;
        logic [READING_W-1:0] blue_reading;
        logic [READING_W-1:0] clear_reading;
    } meas_item_t;

    typedef struct packed {
        logic [PHASE_W-1:0] phase;
        logic [INTEG_W-1:0] color_integration;
        logic [INTEG_W-1:0] clear_integration;
        logic [CAP_W-1:0]   cap_red_out;
        logic [CAP_W-1:0]   cap_green_out;
        logic [CAP_W-1:0]   cap_blue_out;
        logic               measure_request;
        logic [INTEG_W-1:0] color_gain_result;
        logic [INTEG_W-1:0] clear_gain_result;
    } res_item_t;

    // capacitor balancing state, index 0 red, 1 green, 2 blue
    typedef struct packed {
        logic [2:0][CAP_W-1:0] caps;
        logic [2:0][SUM_W-1:0] sums;
        logic [CNT_W-1:0]      count;
        logic [READING_W-1:0]  prev_spread;
    } bal_state_t;

    localparam bal_state_t BAL_INIT = '{
        caps:        '0,
        sums:        '0,
        count:       '0,
        prev_spread: SPREAD_INIT
    };

endpackage

`default_nettype wire

// ===== hdl/color_sensor_gain_calibration_unit.sv =====
// top level of the color sensor gain calibration unit
`default_nettype none

// channel   direction  handshake            payload
// meas      in         meas_valid/stall     meas_item_t: cmd and r, g, b, clear readings
// res       out        res_valid/stall      res_item_t: phase and settings to apply next
// apb       in         psel/penable/pready  target_count at byte address 0
//
// one request per cycle sustained while the result side does not stall; each request gives
// exactly one result, through the input register and then the result register
// all step logic sits between those two registers: one search step (compare,
// halve, add) or one balancing step (three adds, max/min, subtract)
// reset leaves the unit idle with target_count 1000 and all settings zero
// a stalled result holds while one more request can still enter an empty input register

module color_sensor_gain_calibration_unit
    import csgc_pkg::*;
#(
    parameter int SEARCH_RANGE = SEARCH_RANGE_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  meas_valid,
    output logic                  meas_stall,
    input  meas_item_t            meas_data,

    output logic                  res_valid,
    input  logic                  res_stall,
    output res_item_t             res_data,

    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int BOUND_W = $clog2(SEARCH_RANGE + 1);
    localparam int TRIAL_W = $clog2(SEARCH_RANGE);
    localparam int HALF    = SEARCH_RANGE / 2;

    // handshake and pipeline registers
    logic       in_valid_reg;
    meas_item_t in_data_reg;
    logic       res_valid_reg;
    res_item_t  res_data_reg;
    logic       advance;
    logic       accept;

    // calibration state
    logic [READING_W-1:0] target_reg;
    phase_t               phase_reg,   phase_next;
    logic [BOUND_W-1:0]   lower_reg,   lower_next;
    logic [BOUND_W-1:0]   upper_reg,   upper_next;
    logic [TRIAL_W-1:0]   trial_reg,   trial_next;
    logic [TRIAL_W-1:0]   color_reg,   color_next;
    logic [TRIAL_W-1:0]   clear_reg,   clear_next;
    logic [TRIAL_W-1:0]   color_res_reg, color_res_next;
    logic [TRIAL_W-1:0]   clear_res_reg, clear_res_next;
    bal_state_t           bal_reg,     bal_next;
    res_item_t            res_next;

    // step unit outputs
    logic [READING_W-1:0] max_rgb;
    logic [READING_W-1:0] search_reading;
    logic [BOUND_W-1:0]   srch_lower;
    logic [BOUND_W-1:0]   srch_upper;
    logic [TRIAL_W-1:0]   srch_trial;
    logic                 srch_done;
    bal_state_t           bal_step;
    logic                 bal_settled;

    // ------------------------------------------------------------------
    // handshake: the result register decouples the two sides
    // ------------------------------------------------------------------
    assign advance    = in_valid_reg && (!res_valid_reg || !res_stall);
    assign meas_stall = in_valid_reg && res_valid_reg && res_stall;
    assign accept     = meas_valid && !meas_stall;
    assign res_valid  = res_valid_reg;
    assign res_data   = res_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (!res_stall)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_data_reg <= meas_data;
        end
        if (advance)
        begin
            res_data_reg <= res_next;
        end
    end

    // ------------------------------------------------------------------
    // configuration port
    // ------------------------------------------------------------------
    assign pready = 1'b1;

    always_comb
    begin
        prdata = '0;
        if (paddr == REG_ADDR_TARGET)
        begin
            prdata = APB_DATA_W'(target_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg <= TARGET_RESET;
        end
        else if (psel && penable && pwrite && pready && paddr == REG_ADDR_TARGET)
        begin
            target_reg <= pwdata[READING_W-1:0];
        end
    end

    // ------------------------------------------------------------------
    // step units: one shared search step, one balancing step
    // ------------------------------------------------------------------
    always_comb
    begin
        max_rgb = in_data_reg.red_reading;
        if (in_data_reg.green_reading > max_rgb)
        begin
            max_rgb = in_data_reg.green_reading;
        end
        if (in_data_reg.blue_reading > max_rgb)
        begin
            max_rgb = in_data_reg.blue_reading;
        end
    end

    // colour search follows the brightest color channel, clear search the clear channel
    assign search_reading = (phase_reg == PH_CLEAR) ? in_data_reg.clear_reading : max_rgb;

    csgc_search #(
        .SEARCH_RANGE (SEARCH_RANGE)
    ) u_search (
        .reading    (search_reading),
        .target     (target_reg),
        .lower      (lower_reg),
        .upper      (upper_reg),
        .trial      (trial_reg),
        .lower_next (srch_lower),
        .upper_next (srch_upper),
        .trial_next (srch_trial),
        .done       (srch_done)
    );

    csgc_balance u_balance (
        .cur     (bal_reg),
        .red     (in_data_reg.red_reading),
        .green   (in_data_reg.green_reading),
        .blue    (in_data_reg.blue_reading),
        .nxt     (bal_step),
        .settled (bal_settled)
    );

    // ------------------------------------------------------------------
    // next state
    // ------------------------------------------------------------------
    always_comb
    begin
        phase_next     = phase_reg;
        lower_next     = lower_reg;
        upper_next     = upper_reg;
        trial_next     = trial_reg;
        color_next     = color_reg;
        clear_next     = clear_reg;
        color_res_next = color_res_reg;
        clear_res_next = clear_res_reg;
        bal_next       = bal_reg;

        if (advance)
        begin
            if (in_data_reg.cmd == CMD_START)
            begin
                // restart the colour search at the middle of the range
                phase_next     = PH_COLOR;
                color_res_next = '0;
                clear_res_next = '0;
                lower_next     = '0;
                upper_next     = BOUND_W'(SEARCH_RANGE);
                trial_next     = TRIAL_W'(HALF);
                color_next     = TRIAL_W'(HALF);
            end
            else
            begin
                unique case (phase_reg)
                    PH_COLOR:
                    begin
                        lower_next = srch_lower;
                        upper_next = srch_upper;
                        trial_next = srch_trial;
                        if (srch_done)
                        begin
                            // colour integration stays at its last applied value
                            color_res_next = srch_trial;
                            phase_next     = PH_CLEAR;
                            lower_next     = '0;
                            upper_next     = BOUND_W'(SEARCH_RANGE);
                            trial_next     = TRIAL_W'(HALF);
                            clear_next     = TRIAL_W'(HALF);
                        end
                        else
                        begin
                            color_next = srch_trial;
                        end
                    end
                    PH_CLEAR:
                    begin
                        lower_next = srch_lower;
                        upper_next = srch_upper;
                        trial_next = srch_trial;
                        if (srch_done)
                        begin
                            clear_res_next = srch_trial;
                            phase_next     = PH_CAPS;
                            bal_next       = BAL_INIT;
                        end
                        else
                        begin
                            clear_next = srch_trial;
                        end
                    end
                    PH_CAPS:
                    begin
                        bal_next = bal_step;
                        if (bal_settled)
                        begin
                            phase_next = PH_DONE;
                        end
                    end
                    default:
                    begin
                        // idle or done: measurement ignored
                    end
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // result item built from the updated state
    // ------------------------------------------------------------------
    always_comb
    begin
        res_next.phase             = phase_next;
        res_next.color_integration = INTEG_W'(color_next);
        res_next.clear_integration = INTEG_W'(clear_next);
        res_next.cap_red_out       = bal_next.caps[0];
        res_next.cap_green_out     = bal_next.caps[1];
        res_next.cap_blue_out      = bal_next.caps[2];
        res_next.measure_request   = (phase_next == PH_COLOR) || (phase_next == PH_CLEAR)
                                     || (phase_next == PH_CAPS);
        res_next.color_gain_result = INTEG_W'(color_res_next);
        res_next.clear_gain_result = INTEG_W'(clear_res_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            lower_reg     <= '0;
            upper_reg     <= BOUND_W'(SEARCH_RANGE);
            trial_reg     <= '0;
            color_reg     <= '0;
            clear_reg     <= '0;
            color_res_reg <= '0;
            clear_res_reg <= '0;
            bal_reg       <= BAL_INIT;
        end
        else
        begin
            phase_reg     <= phase_next;
            lower_reg     <= lower_next;
            upper_reg     <= upper_next;
            trial_reg     <= trial_next;
            color_reg     <= color_next;
            clear_reg     <= clear_next;
            color_res_reg <= color_res_next;
            clear_res_reg <= clear_res_next;
            bal_reg       <= bal_next;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/csgc_search.sv =====
// one binary search step over the integration range
`default_nettype none

module csgc_search
    import csgc_pkg::*;
#(
    parameter int SEARCH_RANGE = SEARCH_RANGE_DEF
)
(
    input  logic [READING_W-1:0]                   reading,
    input  logic [READING_W-1:0]                   target,
    input  logic [$clog2(SEARCH_RANGE+1)-1:0]      lower,
    input  logic [$clog2(SEARCH_RANGE+1)-1:0]      upper,
    input  logic [$clog2(SEARCH_RANGE)-1:0]        trial,
    output logic [$clog2(SEARCH_RANGE+1)-1:0]      lower_next,
    output logic [$clog2(SEARCH_RANGE+1)-1:0]      upper_next,
    output logic [$clog2(SEARCH_RANGE)-1:0]        trial_next,
    output logic                                   done
);

    localparam int BOUND_W = $clog2(SEARCH_RANGE + 1);
    localparam int TRIAL_W = $clog2(SEARCH_RANGE);

    logic               hit;
    logic [BOUND_W-1:0] mid;

    always_comb
    begin
        lower_next = lower;
        upper_next = upper;
        hit        = 1'b0;
        priority if (reading > target)
        begin
            upper_next = BOUND_W'(trial);
        end
        else if (reading < target)
        begin
            lower_next = BOUND_W'(trial);
        end
        else
        begin
            hit = 1'b1;
        end
        // mid stays below upper, so it fits the trial width
        mid        = lower_next + ((upper_next - lower_next) >> 1);
        trial_next = hit ? trial : TRIAL_W'(mid);
        done       = hit || (mid == lower_next);
    end

endmodule

`default_nettype wire

// ===== hdl/csgc_balance.sv =====
// one capacitor balancing step: accumulate, average and raise the largest channel
`default_nettype none

module csgc_balance
    import csgc_pkg::*;
(
    input  bal_state_t           cur,
    input  logic [READING_W-1:0] red,
    input  logic [READING_W-1:0] green,
    input  logic [READING_W-1:0] blue,
    output bal_state_t           nxt,
    output logic                 settled
);

    logic [2:0][SUM_W-1:0]     sum;
    logic [2:0][READING_W-1:0] avg;
    logic [READING_W-1:0]      mx;
    logic [READING_W-1:0]      mn;
    logic [READING_W-1:0]      spread;
    logic                      raised;

    always_comb
    begin
        sum[0] = cur.sums[0] + SUM_W'(red);
        sum[1] = cur.sums[1] + SUM_W'(green);
        sum[2] = cur.sums[2] + SUM_W'(blue);
        for (int i = 0; i < 3; i++)
        begin
            avg[i] = READING_W'(sum[i] >> AVG_SHIFT);
        end
        mx = avg[0];
        mn = avg[0];
        for (int i = 1; i < 3; i++)
        begin
            if (avg[i] > mx)
            begin
                mx = avg[i];
            end
            if (avg[i] < mn)
            begin
                mn = avg[i];
            end
        end
        spread  = mx - mn;

        nxt     = cur;
        settled = 1'b0;
        raised  = 1'b0;
        if (cur.count != CNT_W'(AVG_SAMPLES - 1))
        begin
            nxt.sums  = sum;
            nxt.count = cur.count + CNT_W'(1);
        end
        else
        begin
            nxt.sums  = '0;
            nxt.count = '0;
            if (spread == cur.prev_spread)
            begin
                settled = 1'b1;
            end
            else
            begin
                // first of red, green, blue at the maximum that still has headroom
                for (int i = 0; i < 3; i++)
                begin
                    if (!raised && avg[i] == mx && cur.caps[i] < CAP_MAX)
                    begin
                        nxt.caps[i] = cur.caps[i] + CAP_W'(1);
                        raised      = 1'b1;
                    end
                end
                nxt.prev_spread = spread;
            end
        end
    end

endmodule

`default_nettype wire

// ===== tb/sv/color_sensor_gain_calibration_unit_tb.sv =====
// testbench of the color sensor gain calibration unit: scene-driven requests, predicted results
`timescale 1ns / 1ps

module color_sensor_gain_calibration_unit_tb;
    import csgc_pkg::*;

    // search bounds need one bit more than the integration value
    localparam int BOUND_W        = $clog2(SEARCH_RANGE_DEF) + 1;
    // cycles with no handshake before the run counts as hung, far above any real gap
    localparam int WATCHDOG_LIMIT = 2000;
    // requests per random phase that reach a calibration step
    localparam int SCENE_GOAL     = 90;
    localparam int CFG_PHASES     = 5;

    // calibration state as the unit should hold it
    typedef struct packed {
        logic [PHASE_W-1:0]    phase;
        logic [BOUND_W-1:0]    lo;
        logic [BOUND_W-1:0]    hi;
        logic [BOUND_W-1:0]    trial;
        logic [INTEG_W-1:0]    color_app;
        logic [INTEG_W-1:0]    clear_app;
        logic [2:0][CAP_W-1:0] caps;
        logic [2:0][SUM_W-1:0] sums;
        logic [CNT_W-1:0]      count;
        logic [READING_W-1:0]  prev_spread;
        logic [INTEG_W-1:0]    color_res;
        logic [INTEG_W-1:0]    clear_res;
    } calib_state_t;

    localparam calib_state_t CALIB_RESET = '{
        phase:       PH_IDLE,
        lo:          '0,
        hi:          BOUND_W'(SEARCH_RANGE_DEF),
        trial:       '0,
        color_app:   '0,
        clear_app:   '0,
        caps:        '0,
        sums:        '0,
        count:       '0,
        prev_spread: SPREAD_INIT,
        color_res:   '0,
        clear_res:   '0
    };

    logic                  clk        = 1'b0;
    logic                  rst_n      = 1'b0;

    logic                  meas_valid = 1'b0;
    logic                  meas_stall;
    meas_item_t            meas_data  = '0;

    logic                  res_valid;
    logic                  res_stall  = 1'b0;
    res_item_t             res_data;

    logic                  psel       = 1'b0;
    logic                  penable    = 1'b0;
    logic                  pwrite     = 1'b0;
    logic [APB_ADDR_W-1:0] paddr      = REG_ADDR_TARGET;
    logic [APB_DATA_W-1:0] pwdata     = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    // requests waiting for the driver, results waiting for the unit
    meas_item_t            meas_backlog [$];
    res_item_t             settings_due [$];

    // predicted state and target register as seen by accepted requests
    calib_state_t          model_state  = CALIB_RESET;
    // state after the last queued request, used to shape the next reading
    calib_state_t          plan_state   = CALIB_RESET;
    logic [READING_W-1:0]  target_reg   = TARGET_RESET;

    int unsigned           items_queued = 0;
    int unsigned           items_taken  = 0;
    int unsigned           mismatch_cnt = 0;
    int unsigned           stuck_cycles = 0;
    int unsigned           send_gap     = 0;
    int unsigned           stall_gap    = 0;
    logic                  meas_taken   = 1'b0;
    // no idle or stall bursts while set
    bit                    calm         = 1'b0;

    color_sensor_gain_calibration_unit i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .meas_valid (meas_valid),
        .meas_stall (meas_stall),
        .meas_data  (meas_data),
        .res_valid  (res_valid),
        .res_stall  (res_stall),
        .res_data   (res_data),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // one line per mismatch, run goes on
    task automatic flag_mismatch(input string what, input longint unsigned got,
                                 input longint unsigned want);
        $display("mismatch: %s got %0d want %0d at %0t", what, got, want, $time);
        mismatch_cnt++;
    endtask

    function automatic logic [BOUND_W-1:0] midpoint(input logic [BOUND_W-1:0] lo,
                                                    input logic [BOUND_W-1:0] hi);
        return lo + ((hi - lo) >> 1);
    endfunction

    // state after one request
    function automatic calib_state_t calib_step(input calib_state_t s, input meas_item_t m,
                                                input logic [READING_W-1:0] target);
        logic [READING_W-1:0]      lvl;
        logic [READING_W-1:0]      hi_avg;
        logic [READING_W-1:0]      lo_avg;
        logic [READING_W-1:0]      spread;
        logic [2:0][READING_W-1:0] rd;
        logic [2:0][READING_W-1:0] avg;
        bit                        found;
        bit                        raised;
        rd[0] = m.red_reading;
        rd[1] = m.green_reading;
        rd[2] = m.blue_reading;
        if (m.cmd == CMD_START)
        begin
            // restart from any phase; caps and clear setting stay until their phase
            s.phase     = PH_COLOR;
            s.color_res = '0;
            s.clear_res = '0;
            s.lo        = '0;
            s.hi        = BOUND_W'(SEARCH_RANGE_DEF);
            s.trial     = midpoint(s.lo, s.hi);
            s.color_app = s.trial[INTEG_W-1:0];
        end
        else if (s.phase == PH_COLOR || s.phase == PH_CLEAR)
        begin
            if (s.phase == PH_COLOR)
            begin
                lvl = rd[0];
                if (rd[1] > lvl)
                    lvl = rd[1];
                if (rd[2] > lvl)
                    lvl = rd[2];
            end
            else
                lvl = m.clear_reading;
            found = 1'b0;
            if (lvl > target)
                s.hi = s.trial;
            else if (lvl < target)
                s.lo = s.trial;
            else
                found = 1'b1;
            if (!found)
            begin
                s.trial = midpoint(s.lo, s.hi);
                found   = (s.trial == s.lo);
            end
            if (found && s.phase == PH_COLOR)
            begin
                // the full range always leaves room for a first clear midpoint
                s.color_res = s.trial[INTEG_W-1:0];
                s.phase     = PH_CLEAR;
                s.lo        = '0;
                s.hi        = BOUND_W'(SEARCH_RANGE_DEF);
                s.trial     = midpoint(s.lo, s.hi);
                s.clear_app = s.trial[INTEG_W-1:0];
            end
            else if (found)
            begin
                s.clear_res   = s.trial[INTEG_W-1:0];
                s.phase       = PH_CAPS;
                s.caps        = '0;
                s.sums        = '0;
                s.count       = '0;
                s.prev_spread = SPREAD_INIT;
            end
            else if (s.phase == PH_COLOR)
                s.color_app = s.trial[INTEG_W-1:0];
            else
                s.clear_app = s.trial[INTEG_W-1:0];
        end
        else if (s.phase == PH_CAPS)
        begin
            for (int i = 0; i < 3; i++)
                s.sums[i] = s.sums[i] + rd[i];
            if (s.count != CNT_W'(AVG_SAMPLES - 1))
                s.count = s.count + 1'b1;
            else
            begin
                for (int i = 0; i < 3; i++)
                    avg[i] = READING_W'(s.sums[i] / AVG_SAMPLES);
                s.sums  = '0;
                s.count = '0;
                hi_avg  = avg[0];
                lo_avg  = avg[0];
                for (int i = 1; i < 3; i++)
                begin
                    if (avg[i] > hi_avg)
                        hi_avg = avg[i];
                    if (avg[i] < lo_avg)
                        lo_avg = avg[i];
                end
                spread = hi_avg - lo_avg;
                if (spread == s.prev_spread)
                    s.phase = PH_DONE;
                else
                begin
                    // red first, then green, then blue; saturated caps are skipped
                    raised = 1'b0;
                    for (int i = 0; i < 3; i++)
                    begin
                        if (!raised && avg[i] == hi_avg && s.caps[i] < CAP_MAX)
                        begin
                            s.caps[i] = s.caps[i] + 1'b1;
                            raised    = 1'b1;
                        end
                    end
                    s.prev_spread = spread;
                end
            end
        end
        return s;
    endfunction

    function automatic res_item_t settings_of(input calib_state_t s);
        res_item_t r;
        r.phase             = s.phase;
        r.color_integration = s.color_app;
        r.clear_integration = s.clear_app;
        r.cap_red_out       = s.caps[0];
        r.cap_green_out     = s.caps[1];
        r.cap_blue_out      = s.caps[2];
        r.measure_request   = (s.phase == PH_COLOR || s.phase == PH_CLEAR || s.phase == PH_CAPS);
        r.color_gain_result = s.color_res;
        r.clear_gain_result = s.clear_res;
        return r;
    endfunction

    task automatic queue_item(input logic cmd, input logic [READING_W-1:0] r,
                              input logic [READING_W-1:0] g, input logic [READING_W-1:0] b,
                              input logic [READING_W-1:0] c);
        meas_item_t m;
        m.cmd           = cmd;
        m.red_reading   = r;
        m.green_reading = g;
        m.blue_reading  = b;
        m.clear_reading = c;
        meas_backlog.push_back(m);
        items_queued++;
        plan_state = calib_step(plan_state, m, target_reg);
    endtask

    // calibration runs against a simple light model, with stray requests mixed in
    task automatic drive_scenes(input int unsigned goal);
        int unsigned done_cnt;
        int unsigned slope;
        int unsigned cslope;
        int unsigned lead;
        int unsigned noise;
        int unsigned peak;
        int unsigned sag;
        int unsigned base [3];
        int unsigned drop [3];
        int unsigned lvl  [4];
        logic        cmd;
        bit          live;
        done_cnt = 0;
        slope    = 16;
        cslope   = 16;
        lead     = 0;
        noise    = 0;
        for (int i = 0; i < 3; i++)
        begin
            base[i] = 0;
            drop[i] = 0;
        end
        while (done_cnt < goal)
        begin
            live = (plan_state.phase == PH_COLOR || plan_state.phase == PH_CLEAR ||
                    plan_state.phase == PH_CAPS);
            cmd  = CMD_MEASURE;
            for (int i = 0; i < 4; i++)
                lvl[i] = $urandom_range(0, 65535);
            if ($urandom_range(0, 11) == 0)
                // stray request: random command and readings
                cmd = 1'($urandom_range(0, 1));
            else if (!live)
            begin
                // new scene, then start
                slope  = $urandom_range(1, 600);
                cslope = $urandom_range(1, 600);
                lead   = $urandom_range(0, 2);
                noise  = $urandom_range(0, 1) ? $urandom_range(0, 7) : 0;
                for (int i = 0; i < 3; i++)
                begin
                    base[i] = $urandom_range(0, 65535 - 7);
                    drop[i] = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 400);
                end
                cmd = CMD_START;
            end
            else if (plan_state.phase == PH_COLOR)
            begin
                // brightest channel grows with integration, sometimes lands on target
                peak = plan_state.color_app * slope / 16;
                if (peak > 65535)
                    peak = 65535;
                if ($urandom_range(0, 15) == 0)
                    peak = 32'(target_reg);
                for (int i = 0; i < 3; i++)
                    lvl[i] = peak * $urandom_range(0, 256) / 256;
                lvl[lead] = peak;
            end
            else if (plan_state.phase == PH_CLEAR)
            begin
                peak = plan_state.clear_app * cslope / 16;
                if (peak > 65535)
                    peak = 65535;
                if ($urandom_range(0, 15) == 0)
                    peak = 32'(target_reg);
                lvl[3] = peak;
            end
            else
            begin
                // each cap step pulls its channel down by a fixed amount
                for (int i = 0; i < 3; i++)
                begin
                    sag    = plan_state.caps[i] * drop[i];
                    lvl[i] = ((base[i] > sag) ? base[i] - sag : 0) + $urandom_range(0, noise);
                end
            end
            queue_item(cmd, READING_W'(lvl[0]), READING_W'(lvl[1]), READING_W'(lvl[2]),
                       READING_W'(lvl[3]));
            if (cmd == CMD_START || live)
                done_cnt++;
        end
    endtask

    // one setup and one access phase on the register port
    task automatic apb_access(input bit wr, input logic [APB_DATA_W-1:0] wdata,
                              output logic [APB_DATA_W-1:0] rdata);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= REG_ADDR_TARGET;
        pwdata  <= wdata;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        rdata = prdata;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // every queued request accepted and every result back
    task automatic wait_idle();
        while (items_taken != items_queued || settings_due.size() != 0)
            @(negedge clk);
    endtask

    // request driver: next request once the current one is taken
    always @(negedge clk)
    begin
        if (!rst_n)
            meas_valid <= 1'b0;
        else if (!meas_valid || meas_taken)
        begin
            if (send_gap > 0)
            begin
                send_gap   <= send_gap - 1;
                meas_valid <= 1'b0;
            end
            else if (!calm && meas_backlog.size() > 0 && $urandom_range(0, 7) == 0)
            begin
                // idle burst of random length set by send_gap, this slot included
                send_gap   <= $urandom_range(0, 4);
                meas_valid <= 1'b0;
            end
            else if (meas_backlog.size() > 0)
            begin
                meas_data  <= meas_backlog.pop_front();
                meas_valid <= 1'b1;
            end
            else
                meas_valid <= 1'b0;
        end
    end

    // result side stalls in bursts of random length set by stall_gap
    always @(negedge clk)
    begin
        if (stall_gap > 0)
        begin
            stall_gap <= stall_gap - 1;
            res_stall <= 1'b1;
        end
        else if (!calm && $urandom_range(0, 7) == 0)
        begin
            stall_gap <= $urandom_range(0, 4);
            res_stall <= 1'b1;
        end
        else
            res_stall <= 1'b0;
    end

    // monitor: check results against the oldest expectation, predict on each request
    always @(posedge clk)
    begin
        res_item_t want;
        if (!rst_n)
            meas_taken <= 1'b0;
        else
        begin
            meas_taken <= meas_valid && !meas_stall;
            if (res_valid && !res_stall)
            begin
                if (settings_due.size() == 0)
                    flag_mismatch("result with no request pending, phase", res_data.phase, 0);
                else
                begin
                    want = settings_due.pop_front();
                    if (res_data.phase !== want.phase)
                        flag_mismatch("phase", res_data.phase, want.phase);
                    if (res_data.color_integration !== want.color_integration)
                        flag_mismatch("color_integration", res_data.color_integration,
                                      want.color_integration);
                    if (res_data.clear_integration !== want.clear_integration)
                        flag_mismatch("clear_integration", res_data.clear_integration,
                                      want.clear_integration);
                    if (res_data.cap_red_out !== want.cap_red_out)
                        flag_mismatch("cap_red_out", res_data.cap_red_out, want.cap_red_out);
                    if (res_data.cap_green_out !== want.cap_green_out)
                        flag_mismatch("cap_green_out", res_data.cap_green_out,
                                      want.cap_green_out);
                    if (res_data.cap_blue_out !== want.cap_blue_out)
                        flag_mismatch("cap_blue_out", res_data.cap_blue_out, want.cap_blue_out);
                    if (res_data.measure_request !== want.measure_request)
                        flag_mismatch("measure_request", res_data.measure_request,
                                      want.measure_request);
                    if (res_data.color_gain_result !== want.color_gain_result)
                        flag_mismatch("color_gain_result", res_data.color_gain_result,
                                      want.color_gain_result);
                    if (res_data.clear_gain_result !== want.clear_gain_result)
                        flag_mismatch("clear_gain_result", res_data.clear_gain_result,
                                      want.clear_gain_result);
                end
            end
            if (meas_valid && !meas_stall)
            begin
                model_state = calib_step(model_state, meas_data, target_reg);
                settings_due.push_back(settings_of(model_state));
                items_taken++;
            end
        end
    end

    // watchdog: too long with no handshake on any port
    always @(posedge clk)
    begin
        if (!rst_n || (meas_valid && !meas_stall) || (res_valid && !res_stall) || psel)
            stuck_cycles <= 0;
        else if (stuck_cycles >= WATCHDOG_LIMIT)
        begin
            $display("[color_sensor_gain_calibration_unit] ERROR");
            $finish;
        end
        else
            stuck_cycles <= stuck_cycles + 1;
    end

    initial
    begin
        logic [APB_DATA_W-1:0] rdata;
        logic [READING_W-1:0]  value;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // target register comes out of reset at its default
        apb_access(1'b0, '0, rdata);
        if (rdata !== APB_DATA_W'(TARGET_RESET))
            flag_mismatch("target_count after reset", rdata, TARGET_RESET);

        // measurement while idle is ignored
        queue_item(CMD_MEASURE, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        queue_item(CMD_START, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        // brightest channel right on target ends the color search at once
        queue_item(CMD_MEASURE, 16'd1000, 16'd0, 16'd999, 16'd0);
        // clear search: above, below, then on target
        queue_item(CMD_MEASURE, 16'h0000, 16'h0000, 16'h0000, 16'hFFFF);
        queue_item(CMD_MEASURE, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        queue_item(CMD_MEASURE, 16'h0000, 16'h0000, 16'h0000, 16'd1000);
        // two balancing rounds with red and green tied: red wins, then spread repeats;
        // blue averages 3/4 and truncates to zero
        for (int k = 0; k < 2; k++)
        begin
            queue_item(CMD_MEASURE, 16'hFFFF, 16'hFFFF, 16'd1, 16'h0000);
            queue_item(CMD_MEASURE, 16'hFFFF, 16'hFFFF, 16'd2, 16'hFFFF);
            queue_item(CMD_MEASURE, 16'hFFFF, 16'hFFFF, 16'd0, 16'h0000);
            queue_item(CMD_MEASURE, 16'hFFFF, 16'hFFFF, 16'd0, 16'hFFFF);
        end
        // measurement after done is ignored
        queue_item(CMD_MEASURE, 16'd5, 16'd5, 16'd5, 16'd5);
        // restart, and restart again in the middle of a search
        queue_item(CMD_START, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        queue_item(CMD_MEASURE, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000);
        queue_item(CMD_START, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        queue_item(CMD_MEASURE, 16'h0000, 16'h0000, 16'hFFFF, 16'h0000);
        queue_item(CMD_START, 16'h0000, 16'h0000, 16'h0000, 16'h0000);

        // random phases, one target setting each: extremes first, no bursts in the last
        for (int ph = 0; ph < CFG_PHASES; ph++)
        begin
            wait_idle();
            repeat (2) @(negedge clk);
            if (ph == 0)
                value = 16'hFFFF;
            else if (ph == 1)
                value = 16'h0000;
            else
                value = READING_W'($urandom_range(0, 65535));
            calm = (ph == CFG_PHASES - 1);
            apb_access(1'b1, APB_DATA_W'(value), rdata);
            target_reg = value;
            apb_access(1'b0, '0, rdata);
            if (rdata !== APB_DATA_W'(value))
                flag_mismatch("target_count readback", rdata, value);
            drive_scenes(SCENE_GOAL);
        end

        wait_idle();
        repeat (8) @(posedge clk);
        if (mismatch_cnt == 0 && settings_due.size() == 0)
            $display("[color_sensor_gain_calibration_unit] OK");
        else
            $display("[color_sensor_gain_calibration_unit] ERROR");
        $finish;
    end

endmodule

// ===== color_sensor_gain_calibration_unit.f =====
hdl/csgc_pkg.sv
hdl/csgc_search.sv
hdl/csgc_balance.sv
hdl/color_sensor_gain_calibration_unit.sv
tb/sv/color_sensor_gain_calibration_unit_tb.sv
